>>> rtl/core/bmg_pkg.sv
// package: formats, constants and shared functions of the gaussian sampler
`timescale 1ns / 1ps
package bmg_pkg;
    localparam int FRAC_BITS_DEF     = 32;
    localparam int CORDIC_STAGES_DEF = 24;
    localparam int CFG_W             = 32;
    localparam int CFG_IDX_W         = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGMA = 1'd1;
    localparam logic [63:0] TWO_LN2_Q63 = 64'hB17217F7D1CF79AC;
    localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
    localparam logic [63:0] GAIN_Q62    = 64'h9B74EDA8 << 30;

    // atan(2^-i) in Q62, truncated alternating series
    function automatic logic [63:0] atan_q62(input int i);
        logic [63:0] acc;
        logic [63:0] t;
        int k;
        int e;
        acc = '0;
        if (i == 0) begin
            acc = PI_Q60;
        end else begin
            for (k = 0; k < 32; k++) begin
                if (i * (2 * k + 1) <= 62) begin
                    e = 62 - i * (2 * k + 1);
                    t = (64'd1 << e) / 64'(2 * k + 1);
                    if (k % 2 == 1) acc = acc - t;
                    else acc = acc + t;
                end
            end
        end
        return acc;
    endfunction
endpackage

>>> rtl/core/bmg_stream_if.sv
// interface: valid/ready stream channel
`timescale 1ns / 1ps
interface bmg_stream_if #(parameter int W = 64);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/bmg_log_pipe.sv
// module: pipelined -log2 by repeated squaring, radius square root
`timescale 1ns / 1ps
module bmg_log_pipe #(
    parameter int FRAC_BITS = bmg_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_ua,
    output logic [63:0] o_r
);
    localparam int F  = FRAC_BITS;
    localparam int SB = F + 3;
    // stages: 1 normalize, F squarings, 2 scale (split product, then sum), SB sqrt bits
    logic [63:0] r_m   [0:F];
    logic [63:0] r_fr  [0:F];
    logic [5:0]  r_n   [0:F];
    logic [63:0] r_r2;
    logic [63:0] r_rt  [0:SB];
    logic [63:0] r_rv  [0:SB];
    logic [31:0] n_u;
    logic [5:0]  n_n;
    logic [127:0] sq [1:F];
    logic [63:0]  n_l;
    logic [127:0] r_ph;
    logic [127:0] r_pl;
    logic [127:0] n_r2;

    always_comb begin
        n_u = (i_ua == 32'd0) ? 32'd1 : i_ua;
        n_n = 6'd0;
        for (int b = 0; b < 32; b++) begin
            if (n_u[b]) n_n = 6'(b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0]  <= n_n;
            r_fr[0] <= '0;
            r_m[0]  <= (n_n >= 6'(F)) ? (64'(n_u) >> (n_n - 6'(F)))
                                      : (64'(n_u) << (6'(F) - n_n));
        end
    end

    // mantissa stays below 2^(F+1), so F+1 bits feed each square
    genvar g;
    generate
        for (g = 1; g <= F; g++) begin : g_sq
            assign sq[g] = (128'(r_m[g-1][F:0]) * 128'(r_m[g-1][F:0])) >> F;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_n[g] <= r_n[g-1];
                    if (sq[g][63:0] >= (64'd2 << F)) begin
                        r_m[g]  <= sq[g][63:0] >> 1;
                        r_fr[g] <= r_fr[g-1] | (64'd1 << (F - g));
                    end else begin
                        r_m[g]  <= sq[g][63:0];
                        r_fr[g] <= r_fr[g-1];
                    end
                end
            end
        end
    endgenerate

    // -log2 stays below 33 in Q.F, so F+6 bits; 2ln2 taken in two 32-bit halves
    always_comb begin
        n_l = (64'(32 - int'(r_n[F])) << F) - r_fr[F];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ph <= 128'(n_l[F+5:0]) * 128'(bmg_pkg::TWO_LN2_Q63[63:32]);
            r_pl <= 128'(n_l[F+5:0]) * 128'(bmg_pkg::TWO_LN2_Q63[31:0]);
        end
    end

    assign n_r2 = (r_ph << 32) + r_pl;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r2     <= 64'(n_r2 >> 63);
            r_rt[0]  <= '0;
        end
    end
    always_comb r_rv[0] = r_r2;

    generate
        for (g = 1; g <= SB; g++) begin : g_sqrt
            logic [63:0]  t;
            logic [127:0] tt;
            assign t  = r_rt[g-1] | (64'd1 << (SB - g));
            assign tt = 128'(t[SB-1:0]) * 128'(t[SB-1:0]);
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rv[g] <= r_rv[g-1];
                    r_rt[g] <= (tt <= (128'(r_rv[g-1]) << F)) ? t : r_rt[g-1];
                end
            end
        end
    endgenerate

    assign o_r = r_rt[SB];
endmodule

>>> rtl/core/bmg_cordic_pipe.sv
// module: pipelined rotation cordic giving the signed cosine in Q62
`timescale 1ns / 1ps
module bmg_cordic_pipe #(
    parameter int CORDIC_STAGES = bmg_pkg::CORDIC_STAGES_DEF,
    parameter int DEPTH         = 100
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_ub,
    output logic [63:0] o_cos
);
    localparam int N = CORDIC_STAGES;
    logic [63:0] r_x [0:N];
    logic [63:0] r_y [0:N];
    logic [63:0] r_z [0:N];
    logic [1:0]  r_q [0:N+1];
    logic [63:0] r_c [0:DEPTH-N-3];
    logic [63:0] r_zh;
    logic [63:0] r_zl;
    logic [127:0] n_z;

    // angle = low 30 bits times pi, pi taken in two 32-bit halves
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zh   <= 64'(i_ub[29:0]) * 64'(bmg_pkg::PI_Q60[63:32]);
            r_zl   <= 64'(i_ub[29:0]) * 64'(bmg_pkg::PI_Q60[31:0]);
            r_q[0] <= i_ub[31:30];
            for (int k = 1; k <= N + 1; k++) r_q[k] <= r_q[k-1];
        end
    end

    assign n_z = (128'(r_zh) << 32) + 128'(r_zl);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= bmg_pkg::GAIN_Q62;
            r_y[0] <= '0;
            r_z[0] <= 64'(n_z >> 29);
        end
    end

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_rot
            localparam int SH = (g > 62) ? 62 : g;
            localparam logic [63:0] ANG = bmg_pkg::atan_q62(SH);
            logic [63:0] dx, dy;
            assign dx = 64'($signed(r_y[g]) >>> SH);
            assign dy = 64'($signed(r_x[g]) >>> SH);
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!r_z[g][63]) begin
                        r_x[g+1] <= r_x[g] - dx;
                        r_y[g+1] <= r_y[g] + dy;
                        r_z[g+1] <= r_z[g] - ANG;
                    end else begin
                        r_x[g+1] <= r_x[g] + dx;
                        r_y[g+1] <= r_y[g] - dy;
                        r_z[g+1] <= r_z[g] + ANG;
                    end
                end
            end
        end
    endgenerate

    // quadrant fold, then delay to match the radius path
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_q[N+1])
                2'd0:    r_c[0] <= r_x[N];
                2'd1:    r_c[0] <= 64'd0 - r_y[N];
                2'd2:    r_c[0] <= 64'd0 - r_x[N];
                default: r_c[0] <= r_y[N];
            endcase
            for (int k = 1; k <= DEPTH - N - 3; k++) r_c[k] <= r_c[k-1];
        end
    end
    assign o_cos = r_c[DEPTH-N-3];
endmodule

>>> rtl/core/box_muller_gaussian_sampler.sv
// throughput: one beat per cycle; the whole datapath advances when the output is free
// the log squaring chain (one stage per fraction bit) and the bitwise root set the depth
// reset: synchronous active low, clears valid bits, mean to 0 and sigma to 1.0
// datapath registers carry no reset
`timescale 1ns / 1ps
module box_muller_gaussian_sampler #(
    parameter int FRAC_BITS     = bmg_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = bmg_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bmg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bmg_pkg::CFG_W-1:0]     i_cfg_data,
    bmg_stream_if.sink                    s_in,
    bmg_stream_if.source                  m_out
);
    // radius path depth: normalize + squarings + two scale stages + sqrt bits
    localparam int RDEPTH = 1 + FRAC_BITS + 2 + FRAC_BITS + 3;
    localparam int LAT    = RDEPTH + 4;

    logic [31:0] r_mean;
    logic [31:0] r_sigma;
    logic [LAT-1:0] r_vld;
    logic        en;
    logic [63:0] rad, cosv;
    logic [63:0] cmag;
    logic        r_neg, r_neg1, r_neg2;
    logic [127:0] r_pa, r_pb;
    logic [63:0] r_zmag;
    logic [63:0] r_mag;
    logic [127:0] n_zm, n_mg;
    logic signed [34:0] n_s;
    logic [31:0] r_smp;
    logic        r_clip;

    // whole pipe stalls only when the last stage holds an untaken beat
    assign en       = !r_vld[LAT-1] || m_out.ready;
    assign s_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean  <= '0;
            r_sigma <= 32'h0001_0000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bmg_pkg::REG_MEAN:  r_mean  <= i_cfg_data;
                bmg_pkg::REG_SIGMA: r_sigma <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], s_in.valid};
        end
    end

    bmg_log_pipe #(.FRAC_BITS(FRAC_BITS)) u_log (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ua  (s_in.data[31:0]),
        .o_r   (rad)
    );

    bmg_cordic_pipe #(.CORDIC_STAGES(CORDIC_STAGES), .DEPTH(RDEPTH)) u_cordic (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ub  (s_in.data[63:32]),
        .o_cos (cosv)
    );

    // z = r * |cos|, cosine magnitude taken in two 32-bit halves
    // radius stays below 2^(FRAC_BITS+3), so z does too
    assign cmag = cosv[63] ? 64'd0 - cosv : cosv;
    assign n_zm = (r_pb << 32) + r_pa;
    // sigma * z
    assign n_mg = 128'(r_sigma) * 128'(r_zmag[FRAC_BITS+3:0]);
    // mean plus or minus magnitude, wide enough to see overflow
    assign n_s  = r_neg2 ? 35'($signed(r_mean)) - $signed({1'b0, r_mag[33:0]})
                         : 35'($signed(r_mean)) + $signed({1'b0, r_mag[33:0]});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pa   <= 128'(rad[FRAC_BITS+2:0]) * 128'(cmag[31:0]);
            r_pb   <= 128'(rad[FRAC_BITS+2:0]) * 128'(cmag[63:32]);
            r_neg  <= cosv[63];
            r_zmag <= 64'(n_zm >> 62);
            r_neg1 <= r_neg;
            r_mag  <= 64'(n_mg >> FRAC_BITS);
            r_neg2 <= r_neg1;
            if ((|r_mag[63:34]) || n_s > 35'sd2147483647 || n_s < -35'sd2147483648) begin
                r_clip <= 1'b1;
                r_smp  <= r_neg2 ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                r_clip <= 1'b0;
                r_smp  <= n_s[31:0];
            end
        end
    end

    assign m_out.valid = r_vld[LAT-1];
    assign m_out.data  = {r_clip, r_smp};

`ifndef SYNTH
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid && $stable(r_smp))
        else $error("result lost under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_out.valid |-> s_in.ready)
        else $error("pipe stalled with empty output");
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && r_clip |-> r_smp == 32'h8000_0000 || r_smp == 32'h7FFF_FFFF)
        else $error("clip off the rail");
`endif
endmodule

>>> verif/box_muller_gaussian_sampler_tb.sv
// testbench: gaussian sampler checked beat by beat against a fixed-point predictor
`timescale 1ns / 1ps
module box_muller_gaussian_sampler_tb;
    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [bmg_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [bmg_pkg::CFG_W-1:0]     i_cfg_data;

    // input beat packs {uniform_b, uniform_a}, output beat packs {clipped, sample}
    bmg_stream_if #(.W(64)) uni_ch ();
    bmg_stream_if #(.W(33)) smp_ch ();

    box_muller_gaussian_sampler i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (uni_ch),
        .m_out      (smp_ch)
    );

    typedef struct packed {
        logic [31:0] sample;
        logic        clipped;
    } t_gauss_result;

    // predicts each sample from the uniforms and holds the samples still owed
    class gauss_scoreboard;
        logic [31:0]   mean_q  = 32'd0;
        logic [31:0]   sigma_q = 32'd65536;
        t_gauss_result pending_samples[$];
        int            mismatches = 0;
        int            n_in = 0;
        int            n_out = 0;
        int            n_clip = 0;

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            mismatches++;
        endtask

        function logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s);
            logic [127:0] p;
            p = 128'(a) * 128'(b);
            return 64'(p >> s);
        endfunction

        // atan(2^-i) in Q62
        function logic [63:0] atan_term(int i);
            logic [63:0] acc;
            int k;
            acc = 64'd0;
            if (i == 0) return bmg_pkg::PI_Q60;
            for (k = 0; i * (2 * k + 1) <= 62; k++) begin
                if (k % 2 == 1) acc = acc - ((64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1));
                else acc = acc + ((64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1));
            end
            return acc;
        endfunction

        // -log2(u / 2^32) in Q32, by leading one plus repeated squaring
        function logic [63:0] minus_log2(logic [31:0] u);
            int n;
            int i;
            logic [63:0] m;
            logic [63:0] frac;
            n = 31;
            while (n > 0 && !u[n]) n--;
            m = 64'(u) << (32 - n);
            frac = 64'd0;
            for (i = 1; i <= 32; i++) begin
                m = mul_shift(m, m, 32);
                if (m >= 64'h2_0000_0000) begin
                    m = m >> 1;
                    frac[32 - i] = 1'b1;
                end
            end
            return (64'(32 - n) << 32) - frac;
        endfunction

        function logic [63:0] root_q32(logic [63:0] v);
            logic [127:0] target;
            logic [63:0]  r;
            logic [63:0]  t;
            int b;
            target = 128'(v) << 32;
            r = 64'd0;
            for (b = 34; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (128'(t) * 128'(t) <= target) r = t;
            end
            return r;
        endfunction

        function t_gauss_result predict(logic [31:0] ua, logic [31:0] ub);
            t_gauss_result res;
            logic [63:0] radius;
            logic [63:0] cval;
            logic [63:0] cmag;
            logic [63:0] mag;
            logic signed [63:0] x;
            logic signed [63:0] y;
            logic signed [63:0] ang;
            logic signed [63:0] dx;
            logic signed [63:0] dy;
            longint s;
            int i;
            // zero first uniform stands for the smallest step
            if (ua == 32'd0) ua = 32'd1;
            radius = root_q32(mul_shift(minus_log2(ua), bmg_pkg::TWO_LN2_Q63, 63));
            ang = mul_shift({34'd0, ub[29:0]}, bmg_pkg::PI_Q60, 29);
            x = 64'h9B74EDA8 << 30;
            y = 64'sd0;
            for (i = 0; i < bmg_pkg::CORDIC_STAGES_DEF; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (!ang[63]) begin
                    x = x - dx; y = y + dy; ang = ang - atan_term(i);
                end else begin
                    x = x + dx; y = y - dy; ang = ang + atan_term(i);
                end
            end
            case (ub[31:30])
                2'd0: cval = x;
                2'd1: cval = -y;
                2'd2: cval = -x;
                default: cval = y;
            endcase
            cmag = cval[63] ? -cval : cval;
            mag = mul_shift({32'd0, sigma_q}, mul_shift(radius, cmag, 62), 32);
            s = cval[63] ? longint'($signed(mean_q)) - longint'(mag)
                         : longint'($signed(mean_q)) + longint'(mag);
            res.clipped = 1'b0;
            if (s > 64'sd2147483647) begin
                s = 64'sd2147483647;
                res.clipped = 1'b1;
            end else if (s < -64'sd2147483648) begin
                s = -64'sd2147483648;
                res.clipped = 1'b1;
            end
            res.sample = s[31:0];
            return res;
        endfunction

        function void note_uniforms(logic [31:0] ua, logic [31:0] ub);
            pending_samples.push_back(predict(ua, ub));
            n_in++;
        endfunction

        task check_sample(logic [31:0] sample, logic clipped);
            t_gauss_result exp_res;
            n_out++;
            if (pending_samples.size() == 0) begin
                report($sformatf("unexpected sample %h", sample));
            end else begin
                exp_res = pending_samples.pop_front();
                if (exp_res.clipped) n_clip++;
                if (sample !== exp_res.sample)
                    report($sformatf("sample %h, predicted %h", sample, exp_res.sample));
                if (clipped !== exp_res.clipped)
                    report($sformatf("clipped %b, predicted %b", clipped, exp_res.clipped));
            end
        endtask
    endclass

    gauss_scoreboard sb;
    bit              hold_req;   // asks the receiver for one long hold-off
    bit              no_idle;    // stretch with no gaps on either side
    int              hold_left;
    int              stall_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard limit on the whole run
    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver: checks each accepted output beat, then decides ready for the next edge
    initial begin
        smp_ch.ready = 1'b0;
        hold_left = 0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && smp_ch.valid && smp_ch.ready)
                sb.check_sample(smp_ch.data[31:0], smp_ch.data[32]);
            if (hold_req) begin
                // long hold-off so the pipeline fills and stalls the input side
                hold_req = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                smp_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                smp_ch.ready <= 1'b0;
            end else begin
                smp_ch.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // offers one input beat and waits for it to be taken; the gap after it follows
    task send_uniforms(logic [31:0] ua, logic [31:0] ub);
        int gap;
        uni_ch.valid <= 1'b1;
        uni_ch.data  <= {ub, ua};
        @(posedge i_clk);
        while (!uni_ch.ready) @(posedge i_clk);
        sb.note_uniforms(ua, ub);
        gap = pick_gap();
        if (gap > 0) begin
            uni_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // register writes happen only with the pipeline drained
    task write_reg(logic [bmg_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        uni_ch.valid <= 1'b0;
        while (sb.pending_samples.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == bmg_pkg::REG_MEAN) sb.mean_q = val;
        else sb.sigma_q = val;
    endtask

    // uniform_a often scaled down so the tail of the radius gets exercised
    task send_random(int count);
        int k;
        logic [31:0] ua;
        for (k = 0; k < count; k++) begin
            if (k % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
            ua = $urandom();
            if ($urandom_range(0, 3) == 0) ua = ua >> $urandom_range(0, 31);
            send_uniforms(ua, $urandom());
        end
        no_idle = 1'b0;
    endtask

    initial begin
        sb = new();
        hold_req = 1'b0;
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = bmg_pkg::REG_MEAN;
        i_cfg_data = 32'd0;
        uni_ch.valid = 1'b0;
        uni_ch.data = 64'd0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, zero and extreme uniforms, all four quadrants
        send_uniforms(32'd0, 32'd0);
        send_uniforms(32'd1, 32'd0);
        send_uniforms(32'hFFFF_FFFF, 32'd0);
        send_uniforms(32'h8000_0000, 32'h4000_0000);
        send_uniforms(32'd0, 32'h8000_0000);
        send_uniforms(32'd0, 32'hC000_0000);
        send_uniforms(32'h0000_0100, 32'hFFFF_FFFF);
        send_uniforms(32'h0001_0000, 32'h3FFF_FFFF);
        send_uniforms(32'h1234_5678, 32'h2000_0000);
        send_uniforms(32'hAAAA_AAAA, 32'h5555_5555);

        // largest sigma with extreme means drives the sum past both limits
        write_reg(bmg_pkg::REG_SIGMA, 32'hFFFF_FFFF);
        write_reg(bmg_pkg::REG_MEAN, 32'h7FFF_FFFF);
        send_uniforms(32'd0, 32'd0);
        send_uniforms(32'd0, 32'h8000_0000);
        send_uniforms(32'hFFFF_FFFF, 32'h4000_0000);
        write_reg(bmg_pkg::REG_MEAN, 32'h8000_0000);
        send_uniforms(32'd0, 32'h8000_0000);
        send_uniforms(32'd0, 32'd0);
        send_uniforms(32'h0000_0001, 32'hC000_0000);

        // zero sigma returns the mean unchanged
        write_reg(bmg_pkg::REG_SIGMA, 32'd0);
        write_reg(bmg_pkg::REG_MEAN, 32'hDEAD_BEEF);
        send_uniforms(32'd0, 32'd0);
        send_uniforms(32'h0000_0002, 32'h9000_0000);
        send_random(200);

        // reset-like settings, with one long output hold-off
        write_reg(bmg_pkg::REG_MEAN, 32'd0);
        write_reg(bmg_pkg::REG_SIGMA, 32'd65536);
        hold_req = 1'b1;
        send_random(400);

        // random settings, mostly moderate sigma
        write_reg(bmg_pkg::REG_MEAN, $urandom());
        write_reg(bmg_pkg::REG_SIGMA, $urandom_range(0, 32'h00FF_FFFF));
        send_random(400);

        write_reg(bmg_pkg::REG_MEAN, 32'h7FFF_0000);
        write_reg(bmg_pkg::REG_SIGMA, $urandom());
        send_random(300);

        write_reg(bmg_pkg::REG_MEAN, 32'h8000_0000);
        write_reg(bmg_pkg::REG_SIGMA, 32'hFFFF_FFFF);
        send_random(280);

        // drain and let the pipeline settle
        uni_ch.valid <= 1'b0;
        while (sb.pending_samples.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);

        $display("covered %0d uniform pairs, %0d samples back, %0d of them clipped",
                 sb.n_in, sb.n_out, sb.n_clip);
        $display("settings swept: zero and full sigma, both mean limits, random values");
        if (sb.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/core/bmg_pkg.sv
rtl/core/bmg_stream_if.sv
rtl/core/bmg_log_pipe.sv
rtl/core/bmg_cordic_pipe.sv
rtl/core/box_muller_gaussian_sampler.sv
verif/box_muller_gaussian_sampler_tb.sv
